@@ rtl/ntew_pkg.sv @@
package ntew_pkg;

   // field widths
   localparam int unsigned VALUE_W    = 30;
   localparam int unsigned REM_W      = 20;
   localparam int unsigned GROUP_W    = 10;
   localparam int unsigned LOW_W      = 7;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned WORD_W     = 5;
   localparam int unsigned MAX_TOKENS = 17;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned LIST_W     = MAX_TOKENS * WORD_W;

   // input range bound
   localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd999999999;

   // group divisors
   localparam logic [VALUE_W-1:0] MILLION  = 30'd1000000;
   localparam logic [REM_W-1:0]   THOUSAND = 20'd1000;
   localparam logic [GROUP_W-1:0] HUNDRED  = 10'd100;
   localparam logic [LOW_W-1:0]   TEN      = 7'd10;
   localparam logic [LOW_W-1:0]   TWENTY   = 7'd20;

   // reciprocals for the constant divisions: floor(x * RECIP >> SHIFT)
   localparam logic [30:0]        MIL_RECIP = 31'd1125899907;
   localparam int unsigned        MIL_SHIFT = 50;
   localparam logic [20:0]        THO_RECIP = 21'd1073742;
   localparam int unsigned        THO_SHIFT = 30;
   localparam logic [GROUP_W-1:0] HUN_RECIP = 10'd656;
   localparam int unsigned        HUN_SHIFT = 16;
   localparam logic [LOW_W-1:0]   TEN_RECIP = 7'd103;
   localparam int unsigned        TEN_SHIFT = 10;

   // word codes
   localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
   localparam logic [WORD_W-1:0] TOK_TWENTY   = 5'd20;
   localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
   localparam logic [WORD_W-1:0] TOK_AND      = 5'd29;
   localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd30;
   localparam logic [WORD_W-1:0] TOK_MILLION  = 5'd31;

   // group positions
   localparam int unsigned GRP_UNI = 0;
   localparam int unsigned GRP_THO = 1;
   localparam int unsigned GRP_MIL = 2;

   typedef logic [2:0][GROUP_W-1:0] groups_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] hun;
      logic [DIGIT_W-1:0] ten;
      logic [DIGIT_W-1:0] one;
      logic [LOW_W-1:0]   low;
   } digits_type;

   typedef digits_type [2:0] number_digits_type;

   typedef struct packed {
      logic [LIST_W-1:0] words;
      logic [CNT_W-1:0]  count;
   } token_list_type;

endpackage

@@ rtl/ntew_split.sv @@
module ntew_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [29:0]           in_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ntew_pkg::groups_type  out_groups
);

   localparam int unsigned NS = 5;

   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS+1:1] adv;

   logic [ntew_pkg::VALUE_W-1:0] n1_ff;
   logic [60:0]                  prod2_ff;
   logic [ntew_pkg::VALUE_W-1:0] n2_ff;
   logic [ntew_pkg::REM_W-1:0]   rem3_ff;
   logic [ntew_pkg::GROUP_W-1:0] mil3_ff;
   logic [40:0]                  prod4_ff;
   logic [ntew_pkg::REM_W-1:0]   rem4_ff;
   logic [ntew_pkg::GROUP_W-1:0] mil4_ff;
   ntew_pkg::groups_type         grp5_ff;

   logic [ntew_pkg::VALUE_W-1:0] n1_in;
   logic [ntew_pkg::GROUP_W-1:0] mil2;
   logic [ntew_pkg::VALUE_W-1:0] mil_prod;
   logic [ntew_pkg::VALUE_W-1:0] rem_full;
   logic [ntew_pkg::GROUP_W-1:0] tho4;
   logic [ntew_pkg::REM_W-1:0]   tho_prod;
   logic [ntew_pkg::REM_W-1:0]   uni_full;

   // stage advance chain, a stage moves when it is empty or the next one moves
   always_comb begin
      adv[NS+1] = out_ready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   // saturate above the range bound
   assign n1_in = (in_value > ntew_pkg::VALUE_MAX) ? ntew_pkg::VALUE_MAX : in_value;

   // millions from the reciprocal product, then the remainder below a million
   assign mil2     = prod2_ff[ntew_pkg::MIL_SHIFT +: ntew_pkg::GROUP_W];
   assign mil_prod = ntew_pkg::VALUE_W'(mil2) * ntew_pkg::MILLION;
   assign rem_full = n2_ff - mil_prod;

   // thousands from the reciprocal product, then the units
   assign tho4     = prod4_ff[ntew_pkg::THO_SHIFT +: ntew_pkg::GROUP_W];
   assign tho_prod = ntew_pkg::REM_W'(tho4) * ntew_pkg::THOUSAND;
   assign uni_full = rem4_ff - tho_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[1]) begin
         n1_ff <= n1_in;
      end
      if (adv[2]) begin
         prod2_ff <= 61'(n1_ff) * 61'(ntew_pkg::MIL_RECIP);
         n2_ff    <= n1_ff;
      end
      if (adv[3]) begin
         rem3_ff <= rem_full[ntew_pkg::REM_W-1:0];
         mil3_ff <= mil2;
      end
      if (adv[4]) begin
         prod4_ff <= 41'(rem3_ff) * 41'(ntew_pkg::THO_RECIP);
         rem4_ff  <= rem3_ff;
         mil4_ff  <= mil3_ff;
      end
      if (adv[5]) begin
         grp5_ff[ntew_pkg::GRP_MIL] <= mil4_ff;
         grp5_ff[ntew_pkg::GRP_THO] <= tho4;
         grp5_ff[ntew_pkg::GRP_UNI] <= uni_full[ntew_pkg::GROUP_W-1:0];
      end
   end

   assign in_ready   = adv[1];
   assign out_valid  = vld_ff[NS];
   assign out_groups = grp5_ff;

   // every group stays below a thousand
   a_group_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] |-> (grp5_ff[ntew_pkg::GRP_MIL] < 10'd1000 &&
                      grp5_ff[ntew_pkg::GRP_THO] < 10'd1000 &&
                      grp5_ff[ntew_pkg::GRP_UNI] < 10'd1000))
      else $error("group out of range");

   // a held output stage keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] && !out_ready |=> vld_ff[NS] && $stable(grp5_ff))
      else $error("stalled group lost");

   // the remainder below a million is in range
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> rem3_ff < 20'd1000000)
      else $error("million remainder out of range");

endmodule

@@ rtl/ntew_digits.sv @@
module ntew_digits (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ntew_pkg::groups_type         in_groups,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ntew_pkg::number_digits_type  out_digits
);

   localparam int unsigned NS = 4;

   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS+1:1] adv;

   logic [2:0][19:0]                      hp1_ff;
   logic [2:0][ntew_pkg::GROUP_W-1:0]     g1_ff;
   logic [2:0][ntew_pkg::DIGIT_W-1:0]     h2_ff;
   logic [2:0][ntew_pkg::LOW_W-1:0]       r2_ff;
   logic [2:0][13:0]                      tp3_ff;
   logic [2:0][ntew_pkg::DIGIT_W-1:0]     h3_ff;
   logic [2:0][ntew_pkg::LOW_W-1:0]       r3_ff;
   ntew_pkg::number_digits_type           dig4_ff;

   logic [2:0][ntew_pkg::DIGIT_W-1:0]     h_in;
   logic [2:0][ntew_pkg::GROUP_W-1:0]     r_full;
   logic [2:0][ntew_pkg::DIGIT_W-1:0]     t_in;
   logic [2:0][ntew_pkg::LOW_W-1:0]       o_full;

   // stage advance chain
   always_comb begin
      adv[NS+1] = out_ready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   // hundreds digit and low part, then tens and ones of the low part
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         h_in[g]   = hp1_ff[g][ntew_pkg::HUN_SHIFT +: ntew_pkg::DIGIT_W];
         r_full[g] = g1_ff[g] - ntew_pkg::GROUP_W'(h_in[g]) * ntew_pkg::HUNDRED;
         t_in[g]   = tp3_ff[g][ntew_pkg::TEN_SHIFT +: ntew_pkg::DIGIT_W];
         o_full[g] = r3_ff[g] - ntew_pkg::LOW_W'(t_in[g]) * ntew_pkg::TEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      for (int g = 0; g < 3; g++) begin
         if (adv[1]) begin
            hp1_ff[g] <= 20'(in_groups[g]) * 20'(ntew_pkg::HUN_RECIP);
            g1_ff[g]  <= in_groups[g];
         end
         if (adv[2]) begin
            h2_ff[g] <= h_in[g];
            r2_ff[g] <= r_full[g][ntew_pkg::LOW_W-1:0];
         end
         if (adv[3]) begin
            tp3_ff[g] <= 14'(r2_ff[g]) * 14'(ntew_pkg::TEN_RECIP);
            h3_ff[g]  <= h2_ff[g];
            r3_ff[g]  <= r2_ff[g];
         end
         if (adv[4]) begin
            dig4_ff[g].hun <= h3_ff[g];
            dig4_ff[g].ten <= t_in[g];
            dig4_ff[g].one <= o_full[g][ntew_pkg::DIGIT_W-1:0];
            dig4_ff[g].low <= r3_ff[g];
         end
      end
   end

   assign in_ready   = adv[1];
   assign out_valid  = vld_ff[NS];
   assign out_digits = dig4_ff;

   // every digit of the units group is below ten
   a_digits_low: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] |-> (dig4_ff[ntew_pkg::GRP_UNI].ten < 4'd10 &&
                      dig4_ff[ntew_pkg::GRP_UNI].one < 4'd10 &&
                      dig4_ff[ntew_pkg::GRP_UNI].hun < 4'd10))
      else $error("units digit out of range");

   // low part below a hundred
   a_low_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (r2_ff[0] < 7'd100 && r2_ff[1] < 7'd100 && r2_ff[2] < 7'd100))
      else $error("low part out of range");

   // a held output stage keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] && !out_ready |=> vld_ff[NS] && $stable(dig4_ff))
      else $error("stalled digits lost");

endmodule

@@ rtl/ntew_tokens.sv @@
module ntew_tokens (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ntew_pkg::number_digits_type  in_digits,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ntew_pkg::token_list_type     out_list
);

   localparam int unsigned NS = 2;

   typedef struct packed {
      logic [29:0] words;
      logic [2:0]  len;
   } group_list_type;

   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS+1:1] adv;

   group_list_type [2:0]      lst1_ff;
   group_list_type [2:0]      lst1_in;
   ntew_pkg::token_list_type  list2_ff;
   ntew_pkg::token_list_type  list2_in;

   logic [6:0] shift_tho;
   logic [6:0] shift_uni;

   // add one word at the end of a group list
   function automatic group_list_type append(group_list_type lst,
                                             logic [ntew_pkg::WORD_W-1:0] tok);
      group_list_type res;
      res       = lst;
      res.words = lst.words | (30'(tok) << (5 * lst.len));
      res.len   = lst.len + 3'd1;
      return res;
   endfunction

   // words of one group of three digits, with its scale word when it has one and is not zero
   function automatic group_list_type build_group(ntew_pkg::digits_type d,
                                                  logic has_scale,
                                                  logic [ntew_pkg::WORD_W-1:0] scale);
      group_list_type res;
      res = '0;
      if (d.hun != '0) begin
         res = append(res, ntew_pkg::WORD_W'(d.hun));
         res = append(res, ntew_pkg::TOK_HUNDRED);
         if (d.low != '0) begin
            res = append(res, ntew_pkg::TOK_AND);
         end
      end
      if (d.low != '0) begin
         if (d.low <= ntew_pkg::TWENTY) begin
            res = append(res, ntew_pkg::WORD_W'(d.low));
         end else begin
            res = append(res, ntew_pkg::TOK_TWENTY + ntew_pkg::WORD_W'(d.ten) - 5'd2);
            if (d.one != '0) begin
               res = append(res, ntew_pkg::WORD_W'(d.one));
            end
         end
      end
      if (has_scale && (d.hun != '0 || d.low != '0)) begin
         res = append(res, scale);
      end
      return res;
   endfunction

   // stage advance chain
   always_comb begin
      adv[NS+1] = out_ready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   // one list per group
   always_comb begin
      lst1_in[ntew_pkg::GRP_MIL] = build_group(in_digits[ntew_pkg::GRP_MIL], 1'b1,
                                               ntew_pkg::TOK_MILLION);
      lst1_in[ntew_pkg::GRP_THO] = build_group(in_digits[ntew_pkg::GRP_THO], 1'b1,
                                               ntew_pkg::TOK_THOUSAND);
      lst1_in[ntew_pkg::GRP_UNI] = build_group(in_digits[ntew_pkg::GRP_UNI], 1'b0,
                                               ntew_pkg::TOK_ZERO);
   end

   // join the three lists, an empty number reads as zero
   assign shift_tho = 7'(5 * lst1_ff[ntew_pkg::GRP_MIL].len);
   assign shift_uni = 7'(5 * (4'(lst1_ff[ntew_pkg::GRP_MIL].len) +
                              4'(lst1_ff[ntew_pkg::GRP_THO].len)));

   always_comb begin
      list2_in.words = ntew_pkg::LIST_W'(lst1_ff[ntew_pkg::GRP_MIL].words) |
                       (ntew_pkg::LIST_W'(lst1_ff[ntew_pkg::GRP_THO].words) << shift_tho) |
                       (ntew_pkg::LIST_W'(lst1_ff[ntew_pkg::GRP_UNI].words) << shift_uni);
      list2_in.count = ntew_pkg::CNT_W'(lst1_ff[ntew_pkg::GRP_MIL].len) +
                       ntew_pkg::CNT_W'(lst1_ff[ntew_pkg::GRP_THO].len) +
                       ntew_pkg::CNT_W'(lst1_ff[ntew_pkg::GRP_UNI].len);
      if (list2_in.count == '0) begin
         list2_in.words = ntew_pkg::LIST_W'(ntew_pkg::TOK_ZERO);
         list2_in.count = ntew_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[1]) begin
         lst1_ff <= lst1_in;
      end
      if (adv[2]) begin
         list2_ff <= list2_in;
      end
   end

   assign in_ready  = adv[1];
   assign out_valid = vld_ff[NS];
   assign out_list  = list2_ff;

   // word count of a number is one to seventeen
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] |-> (list2_ff.count != '0 && list2_ff.count <= 5'd17))
      else $error("word count out of range");

   // a group list holds at most six words
   a_group_len: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (lst1_ff[0].len <= 3'd5 && lst1_ff[1].len <= 3'd6 &&
                     lst1_ff[2].len <= 3'd6))
      else $error("group list too long");

   // a held output stage keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] && !out_ready |=> vld_ff[NS] && $stable(list2_ff))
      else $error("stalled list lost");

endmodule

@@ rtl/ntew_emit.sv @@
module ntew_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  ntew_pkg::token_list_type            in_list,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ntew_pkg::WORD_W-1:0]         out_word,
   output logic                                out_last
);

   logic                         buf_vld_ff;
   logic [ntew_pkg::LIST_W-1:0]  buf_words_ff;
   logic [ntew_pkg::CNT_W-1:0]   left_ff;
   logic                         out_vld_ff;
   logic [ntew_pkg::WORD_W-1:0]  out_word_ff;
   logic                         out_last_ff;

   logic out_free;
   logic send;
   logic send_last;
   logic load;

   // output register takes a word when empty or being taken
   assign out_free  = !out_vld_ff || out_ready;
   assign send      = buf_vld_ff && out_free;
   assign send_last = send && (left_ff == ntew_pkg::CNT_W'(1));
   assign in_ready  = !buf_vld_ff || send_last;
   assign load      = in_valid && in_ready;

   // word buffer shifts one word out per cycle while the output register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (load) begin
            buf_vld_ff <= 1'b1;
         end else if (send_last) begin
            buf_vld_ff <= 1'b0;
         end
         if (out_free) begin
            out_vld_ff <= buf_vld_ff;
         end
      end
      if (send) begin
         out_word_ff <= buf_words_ff[ntew_pkg::WORD_W-1:0];
         out_last_ff <= (left_ff == ntew_pkg::CNT_W'(1));
      end
      // a new list replaces the one whose final word goes out
      if (load) begin
         buf_words_ff <= in_list.words;
         left_ff      <= in_list.count;
      end else if (send) begin
         buf_words_ff <= buf_words_ff >> ntew_pkg::WORD_W;
         left_ff      <= left_ff - ntew_pkg::CNT_W'(1);
      end
   end

   assign out_valid = out_vld_ff;
   assign out_word  = out_word_ff;
   assign out_last  = out_last_ff;

   // a live buffer always has words left
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      buf_vld_ff |-> (left_ff != '0 && left_ff <= 5'd17))
      else $error("buffer count out of range");

   // the buffer stays live until its final word is sent
   a_keep_buf: assert property (@(posedge clock) disable iff (reset)
      send && !send_last |=> buf_vld_ff)
      else $error("buffer dropped early");

   // the last flag follows the final word of the buffer
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      send |=> out_vld_ff && (out_last_ff == $past(left_ff == 5'd1)))
      else $error("last flag wrong");

endmodule

@@ rtl/number_to_english_words.sv @@
// channel | dir | handshake            | contents
// req     | in  | req_tvalid/tready    | tdata[29:0] value, upper bits zero
// rsp     | out | rsp_tvalid/tready    | tdata[4:0] word, upper bits zero; tlast last
//
// a number enters every cycle while the input side is free; the result side gives
// one word a cycle while rsp_tready is high, so a number of n words (1..17) holds
// that side until its last word is taken; on the way a number passes five stages of
// group split, four of digit split, two of word list building, buffer and output
// reset clears the valid bits of every stage; data registers are not reset
// a stall on the result side backs up stage by stage, nothing is lost or repeated
module number_to_english_words (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [29:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] word
   output logic        rsp_tlast
);

   ntew_pkg::groups_type         groups;
   ntew_pkg::number_digits_type  digits;
   ntew_pkg::token_list_type     list;

   logic split_valid;
   logic digits_ready;
   logic digits_valid;
   logic tokens_ready;
   logic tokens_valid;
   logic emit_ready;

   logic [ntew_pkg::WORD_W-1:0] word;

   // value into million, thousand and unit groups
   ntew_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_value   (req_tdata[ntew_pkg::VALUE_W-1:0]),
      .out_valid  (split_valid),
      .out_ready  (digits_ready),
      .out_groups (groups)
   );

   // each group into its digits
   ntew_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (split_valid),
      .in_ready   (digits_ready),
      .in_groups  (groups),
      .out_valid  (digits_valid),
      .out_ready  (tokens_ready),
      .out_digits (digits)
   );

   // digits into a list of words
   ntew_tokens u_tokens (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (digits_valid),
      .in_ready  (tokens_ready),
      .in_digits (digits),
      .out_valid (tokens_valid),
      .out_ready (emit_ready),
      .out_list  (list)
   );

   // list out one word a cycle while the output side is free
   ntew_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tokens_valid),
      .in_ready  (emit_ready),
      .in_list   (list),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, word};

endmodule
